@@ hw/rtl/apmd_pkg.sv @@
// Shared types and constants for the approximate pattern match distance block.
`timescale 1ns / 1ps

package apmd_pkg;

    localparam int BYTE_W    = 8;
    localparam int DIST_W    = 6;
    localparam int WORD_W    = 64;
    localparam int PAT_WORDS = 4;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEN     = 3'd0,
        CFG_PAT_0_7 = 3'd1,
        CFG_PAT_8   = 3'd2,
        CFG_PAT_16  = 3'd3,
        CFG_PAT_24  = 3'd4
    } t_cfg_idx;

    // One text byte travelling down the cell chain
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] ch;
        logic              last;
        logic [DIST_W-1:0] nxt;   // new column value of the cell to the left
        logic [DIST_W-1:0] old;   // column value the left cell held before this byte
        logic [DIST_W-1:0] here;  // value picked up at the cell at the pattern end
    } t_wave;

endpackage

@@ hw/rtl/apmd_cell.sv @@
// One pattern position of the systolic edit-distance chain.
`timescale 1ns / 1ps

module apmd_cell #(
    parameter int IDX = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_restart,
    input  logic [apmd_pkg::BYTE_W-1:0]       i_pat,
    input  logic [apmd_pkg::DIST_W-1:0]       i_len,
    input  apmd_pkg::t_wave                   i_wave,
    output apmd_pkg::t_wave                   o_wave
);
    import apmd_pkg::*;

    localparam logic [DIST_W-1:0] RST_VAL = DIST_W'(IDX);

    logic [DIST_W-1:0] r_d;
    t_wave             r_wave;
    logic [DIST_W-1:0] diag, up, left, v, here_n;

    always_comb begin
        diag = i_wave.old + ((i_pat != i_wave.ch) ? DIST_W'(1) : DIST_W'(0));
        up   = r_d + DIST_W'(1);
        left = i_wave.nxt + DIST_W'(1);
        v    = (up < left) ? up : left;
        if (diag < v) begin
            v = diag;
        end
        here_n = (i_len == RST_VAL) ? v : i_wave.here;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d          <= RST_VAL;
            r_wave.valid <= 1'b0;
        end else if (i_restart) begin
            r_d <= RST_VAL;
        end else if (i_adv) begin
            r_wave.valid <= i_wave.valid;
            if (i_wave.valid) begin
                // column goes back to its start value after the last byte
                r_d <= i_wave.last ? RST_VAL : v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_wave.valid) begin
            r_wave.ch   <= i_wave.ch;
            r_wave.last <= i_wave.last;
            r_wave.nxt  <= v;
            r_wave.old  <= r_d;
            r_wave.here <= here_n;
        end
    end

    assign o_wave = r_wave;

endmodule

@@ hw/rtl/approximate_pattern_match_distance.sv @@
// Top level: Sellers' approximate match distance over a chain of pattern cells.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  input    | i_in_valid / o_in_stall   | i_text_byte, i_end_of_text
//  output   | o_out_valid / i_out_stall | o_distance_here, o_best_distance, o_final_res
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One text byte enters per cycle while o_in_stall is low; each result passes through
// the cell chain, one registered cell per pattern position, and then through the
// output register that tracks the running minimum.
// Reset (synchronous, active low) clears the pattern and all valid bits and sets
// column entry i back to i.
// An output stall while a result is waiting freezes the whole chain and stalls the input.
`timescale 1ns / 1ps

module approximate_pattern_match_distance #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [apmd_pkg::BYTE_W-1:0]        i_text_byte,
    input  logic                               i_end_of_text,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [apmd_pkg::DIST_W-1:0]        o_distance_here,
    output logic [apmd_pkg::DIST_W-1:0]        o_best_distance,
    output logic                               o_final_res,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [apmd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [apmd_pkg::WORD_W-1:0]        i_cfg_data
);
    import apmd_pkg::*;

    localparam logic [DIST_W-1:0] MAX_LEN = DIST_W'(MAX_PATTERN);

    logic [DIST_W-1:0] r_len;
    logic [WORD_W-1:0] r_pat [PAT_WORDS];
    logic [DIST_W-1:0] r_best;
    logic              r_out_valid;
    logic [DIST_W-1:0] r_out_here, r_out_best;
    logic              r_out_final;

    logic              adv, cfg_wr, restart;
    logic [DIST_W-1:0] eff_len, new_len, n_best;
    t_wave             wave [MAX_PATTERN+1];

    assign adv         = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !adv;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign restart     = cfg_wr && (i_cfg_index == CFG_LEN);
    assign eff_len     = (r_len > MAX_LEN) ? MAX_LEN : r_len;
    assign new_len     = (i_cfg_data[DIST_W-1:0] > MAX_LEN) ? MAX_LEN
                                                             : i_cfg_data[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            for (int k = 0; k < PAT_WORDS; k++) begin
                r_pat[k] <= '0;
            end
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_LEN:     r_len    <= i_cfg_data[DIST_W-1:0];
                CFG_PAT_0_7: r_pat[0] <= i_cfg_data;
                CFG_PAT_8:   r_pat[1] <= i_cfg_data;
                CFG_PAT_16:  r_pat[2] <= i_cfg_data;
                CFG_PAT_24:  r_pat[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Row zero of the column is always zero
    assign wave[0] = '{valid: i_in_valid, ch: i_text_byte, last: i_end_of_text,
                       nxt: '0, old: '0, here: '0};

    for (genvar g = 1; g <= MAX_PATTERN; g++) begin : g_cell
        localparam int P = g - 1;
        apmd_cell #(.IDX(g)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (adv),
            .i_restart (restart),
            .i_pat     (r_pat[P / 8][(P % 8) * BYTE_W +: BYTE_W]),
            .i_len     (eff_len),
            .i_wave    (wave[g-1]),
            .o_wave    (wave[g])
        );
    end

    assign n_best = (wave[MAX_PATTERN].here < r_best) ? wave[MAX_PATTERN].here : r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_best      <= '0;
        end else if (restart) begin
            r_best <= new_len;
        end else if (adv) begin
            r_out_valid <= wave[MAX_PATTERN].valid;
            if (wave[MAX_PATTERN].valid) begin
                r_best <= wave[MAX_PATTERN].last ? eff_len : n_best;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && wave[MAX_PATTERN].valid) begin
            r_out_here  <= wave[MAX_PATTERN].here;
            r_out_best  <= n_best;
            r_out_final <= wave[MAX_PATTERN].last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_distance_here = r_out_here;
    assign o_best_distance = r_out_best;
    assign o_final_res     = r_out_final;

endmodule

@@ hw/rtl/apmd_checker.sv @@
// Port-level checks for the approximate pattern match distance block.
`timescale 1ns / 1ps

module apmd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [apmd_pkg::DIST_W-1:0]    o_distance_here,
    input logic [apmd_pkg::DIST_W-1:0]    o_best_distance,
    input logic                           o_final_res
);

    // a waiting result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_distance_here)
            && $stable(o_best_distance) && $stable(o_final_res))
        else $error("stalled result changed");

    // running minimum includes the current byte
    a_best_le_here: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_best_distance <= o_distance_here)
        else $error("best distance above distance here");

    // input only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present right after reset");

endmodule

bind approximate_pattern_match_distance apmd_checker u_apmd_checker (.*);

@@ verif/approximate_pattern_match_distance_tb.sv @@
// Testbench for the approximate pattern match distance block: directed and random texts.
`timescale 1ns / 1ps

module approximate_pattern_match_distance_tb;
    import apmd_pkg::*;

    localparam int MAX_PAT    = 32;
    localparam int COL_DEPTH  = MAX_PAT + 1;
    localparam int DRAIN_WAIT = MAX_PAT + 8;
    localparam int HOLD_LONG  = 300;
    localparam int RANDOM_ITEMS = 520;
    localparam int RANDOM_PHASES = 8;
    localparam int IDLE_PCT   = 23;
    // index codes that decode to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct {
        logic [DIST_W-1:0] here;
        logic [DIST_W-1:0] best;
        logic              last;
    } t_match_res;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [BYTE_W-1:0]     i_text_byte = '0;
    logic                  i_end_of_text = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [DIST_W-1:0]     o_distance_here;
    logic [DIST_W-1:0]     o_best_distance;
    logic                  o_final_res;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [WORD_W-1:0]     i_cfg_data = '0;

    // mirror of the block's state and registers
    logic [DIST_W-1:0]     dist_col [COL_DEPTH];
    logic [DIST_W-1:0]     best_so_far;
    logic [DIST_W-1:0]     pat_len;
    logic [WORD_W-1:0]     pat_words [PAT_WORDS];

    t_match_res            match_q [$];
    int                    mismatch_count = 0;
    int                    bytes_sent = 0;
    bit                    gaps_on = 1'b1;
    bit                    stalls_on = 1'b1;
    int                    hold_req = 0;
    int                    hold_left = 0;

    always #6 i_clk = ~i_clk;

    approximate_pattern_match_distance #(
        .MAX_PATTERN(MAX_PAT)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_text_byte    (i_text_byte),
        .i_end_of_text  (i_end_of_text),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_distance_here(o_distance_here),
        .o_best_distance(o_best_distance),
        .o_final_res    (o_final_res),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // ---------------- predictor ----------------
    function automatic int active_len();
        return (pat_len > MAX_PAT) ? MAX_PAT : int'(pat_len);
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_at(input int pos);
        return pat_words[pos / 8][(pos % 8) * BYTE_W +: BYTE_W];
    endfunction

    function automatic void restart_column();
        for (int i = 0; i < COL_DEPTH; i++) dist_col[i] = DIST_W'(i);
        best_so_far = DIST_W'(active_len());
    endfunction

    function automatic t_match_res advance_column(input logic [BYTE_W-1:0] ch,
                                                  input logic last);
        int         nxt [COL_DEPTH];
        int         m;
        int         diag;
        int         v;
        t_match_res r;
        m = active_len();
        nxt[0] = 0;
        for (int i = 1; i <= m; i++) begin
            diag = dist_col[i-1] + ((pattern_at(i-1) == ch) ? 0 : 1);
            v = dist_col[i] + 1;
            if (nxt[i-1] + 1 < v) v = nxt[i-1] + 1;
            if (diag < v) v = diag;
            nxt[i] = v;
        end
        for (int i = 1; i <= m; i++) dist_col[i] = DIST_W'(nxt[i]);
        dist_col[0] = '0;
        r.here = DIST_W'(nxt[m]);
        if (r.here < best_so_far) best_so_far = r.here;
        r.best = best_so_far;
        r.last = last;
        if (last) restart_column();
        return r;
    endfunction

    function automatic void mirror_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                             input logic [WORD_W-1:0] data);
        case (idx)
            CFG_LEN: begin
                pat_len = data[DIST_W-1:0];
                restart_column();
            end
            CFG_PAT_0_7: pat_words[0] = data;
            CFG_PAT_8:   pat_words[1] = data;
            CFG_PAT_16:  pat_words[2] = data;
            CFG_PAT_24:  pat_words[3] = data;
            default: ;
        endcase
    endfunction

    // ---------------- receiver side ----------------
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= stalls_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_match_res exp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (match_q.size() == 0) begin
                $error("result with nothing expected: distance_here %0d best_distance %0d",
                       o_distance_here, o_best_distance);
                mismatch_count++;
            end else begin
                exp = match_q.pop_front();
                if (o_distance_here !== exp.here) begin
                    $error("distance_here: expected %0d, got %0d", exp.here, o_distance_here);
                    mismatch_count++;
                end
                if (o_best_distance !== exp.best) begin
                    $error("best_distance: expected %0d, got %0d", exp.best, o_best_distance);
                    mismatch_count++;
                end
                if (o_final_res !== exp.last) begin
                    $error("final_res: expected %0d, got %0d", exp.last, o_final_res);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------- sender side ----------------
    // valid stays high between back-to-back transactions; this task lowers it only for a gap
    task automatic send_text_byte(input logic [BYTE_W-1:0] ch, input logic last);
        if (gaps_on && ($urandom_range(99) < IDLE_PCT)) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_text_byte   <= ch;
        i_end_of_text <= last;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        match_q.push_back(advance_column(ch, last));
        bytes_sent++;
    endtask

    task automatic send_text(input logic [BYTE_W-1:0] txt [$], input logic last);
        for (int i = 0; i < txt.size(); i++)
            send_text_byte(txt[i], last && (i == txt.size() - 1));
    endtask

    task automatic wait_pipeline_empty();
        i_in_valid <= 1'b0;
        while (match_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        mirror_reg_write(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte(input bit narrow);
        return narrow ? BYTE_W'(8'h61 + $urandom_range(3)) : BYTE_W'($urandom_range(255));
    endfunction

    function automatic logic [WORD_W-1:0] pick_word(input bit narrow);
        logic [WORD_W-1:0] w;
        w = {$urandom, $urandom};
        if (narrow)
            for (int b = 0; b < 8; b++) w[b*BYTE_W +: BYTE_W] = pick_byte(1'b1);
        return w;
    endfunction

    // length goes last so the text restarts against the new pattern
    task automatic load_pattern(input logic [DIST_W-1:0] len, input bit narrow);
        write_reg(CFG_PAT_0_7, pick_word(narrow));
        write_reg(CFG_PAT_8,   pick_word(narrow));
        write_reg(CFG_PAT_16,  pick_word(narrow));
        write_reg(CFG_PAT_24,  pick_word(narrow));
        write_reg(CFG_LEN, WORD_W'({$urandom, $urandom, len}));
    endtask

    // the pattern itself with sparse edits, wrapped in noise
    task automatic send_noisy_copy(input bit narrow);
        logic [BYTE_W-1:0] txt [$];
        int                roll;
        repeat ($urandom_range(0, 5)) txt.push_back(pick_byte(narrow));
        for (int i = 0; i < active_len(); i++) begin
            roll = $urandom_range(99);
            if (roll < 7)       txt.push_back(pick_byte(narrow));
            else if (roll < 14) ;
            else if (roll < 20) begin
                txt.push_back(pick_byte(narrow));
                txt.push_back(pattern_at(i));
            end else            txt.push_back(pattern_at(i));
        end
        repeat ($urandom_range(0, 5)) txt.push_back(pick_byte(narrow));
        if (txt.size() == 0) txt.push_back(pick_byte(narrow));
        send_text(txt, 1'b1);
    endtask

    task automatic send_noise_text(input bit narrow);
        logic [BYTE_W-1:0] txt [$];
        repeat ($urandom_range(1, 20)) txt.push_back(pick_byte(narrow));
        send_text(txt, 1'b1);
    endtask

    // ---------------- tests ----------------
    task automatic test_empty_pattern();
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'hFF, 1'b0);
        send_text_byte(8'h55, 1'b1);
        wait_pipeline_empty();
    endtask

    task automatic test_full_pattern();
        logic [BYTE_W-1:0] txt [$];
        load_pattern(DIST_W'(MAX_PAT), 1'b0);
        for (int i = 0; i < MAX_PAT; i++) txt.push_back(pattern_at(i));
        send_text(txt, 1'b1);
        send_text_byte(~pattern_at(0), 1'b1);
        wait_pipeline_empty();
    endtask

    task automatic test_length_clamp();
        write_reg(CFG_LEN, '1);
        send_text_byte(pattern_at(0), 1'b0);
        send_text_byte(pattern_at(1), 1'b1);
        wait_pipeline_empty();
        write_reg(CFG_LEN, WORD_W'(MAX_PAT + 1));
        send_text_byte(pattern_at(0), 1'b1);
        wait_pipeline_empty();
    endtask

    task automatic test_single_byte();
        load_pattern(DIST_W'(1), 1'b0);
        send_text_byte(~pattern_at(0), 1'b0);
        send_text_byte(pattern_at(0), 1'b0);
        send_text_byte(~pattern_at(0), 1'b1);
        wait_pipeline_empty();
    endtask

    // a length write in the middle of a text starts it over
    task automatic test_length_restart();
        load_pattern(DIST_W'(4), 1'b1);
        send_text_byte(pattern_at(0), 1'b0);
        send_text_byte(pattern_at(1), 1'b0);
        send_text_byte(pattern_at(2), 1'b0);
        wait_pipeline_empty();
        write_reg(CFG_LEN, WORD_W'(4));
        send_text_byte(pattern_at(3), 1'b1);
        wait_pipeline_empty();
    endtask

    // pattern byte writes keep the column of the current text
    task automatic test_pattern_midtext();
        send_text_byte(pattern_at(0), 1'b0);
        send_text_byte(pattern_at(1), 1'b0);
        wait_pipeline_empty();
        write_reg(CFG_PAT_0_7, pick_word(1'b1));
        send_text_byte(pattern_at(2), 1'b0);
        send_text_byte(pattern_at(3), 1'b1);
        wait_pipeline_empty();
    endtask

    task automatic test_spare_index();
        for (int k = CFG_SPARE_LO; k <= CFG_SPARE_HI; k++)
            write_reg(CFG_IDX_W'(k), '1);
        send_text_byte(pattern_at(0), 1'b0);
        send_text_byte(8'hFF, 1'b1);
        wait_pipeline_empty();
    endtask

    // receiver holds off while bytes keep coming, so the chain fills
    task automatic test_backpressure();
        load_pattern(DIST_W'(8), 1'b1);
        gaps_on = 1'b0;
        hold_req = HOLD_LONG;
        repeat (4) send_noisy_copy(1'b1);
        repeat (40) send_text_byte(pick_byte(1'b1), 1'b0);
        send_text_byte(pick_byte(1'b0), 1'b1);
        wait_pipeline_empty();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_texts();
        int  target;
        int  len;
        bit  narrow;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            narrow = (ph % 2 == 0) || ($urandom_range(3) == 0);
            case (ph)
                0: len = 1;
                1: len = MAX_PAT;
                2: len = $urandom_range(MAX_PAT + 1, (1 << DIST_W) - 1);
                3: len = 0;
                default: len = $urandom_range(2, MAX_PAT - 1);
            endcase
            // one phase runs without any idling on either side
            gaps_on   = (ph != 4);
            stalls_on = (ph != 4);
            load_pattern(DIST_W'(len), narrow);
            target = bytes_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (bytes_sent < target) begin
                if ($urandom_range(99) < 70) send_noisy_copy(narrow);
                else                         send_noise_text(narrow);
            end
            wait_pipeline_empty();
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial begin
        pat_len = '0;
        for (int w = 0; w < PAT_WORDS; w++) pat_words[w] = '0;
        restart_column();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_pattern();
        test_full_pattern();
        test_length_clamp();
        test_single_byte();
        test_length_restart();
        test_pattern_midtext();
        test_spare_index();
        test_backpressure();
        test_random_texts();

        wait_pipeline_empty();
        if (mismatch_count == 0 && match_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
